FILE: rtl/core/battery_thermal_zone_classifier_macros.svh
// ----------------------------------------------------------------------------
// Battery thermal zone classifier assertion macros
// Shared property wrappers for the checker. Every property is sampled on
// the rising clock edge and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BATTERY_THERMAL_ZONE_CLASSIFIER_MACROS_SVH
`define BATTERY_THERMAL_ZONE_CLASSIFIER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTZC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btzc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BTZC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btzc assertion failed");

`endif

FILE: rtl/core/btzc_pkg.sv
// ----------------------------------------------------------------------------
// Battery thermal zone classifier package
// Types, register indexes and output codes shared by the classifier files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btzc_pkg;

    // Temperature samples and thresholds, tenths of a degree.
    typedef logic signed [11:0] temp_t;
    // Boundaries after hysteresis adjustment need one more bit.
    typedef logic signed [12:0] bound_t;

    typedef enum logic [2:0] {
        ZONE_COLD     = 3'd0,
        ZONE_COOL3    = 3'd1,
        ZONE_COOL2    = 3'd2,
        ZONE_COOL1    = 3'd3,
        ZONE_NORMAL   = 3'd4,
        ZONE_WARM     = 3'd5,
        ZONE_OVERHEAT = 3'd6
    } zone_t;

    localparam bound_t COOL_HYST         = 13'sd19;
    localparam bound_t D2D_RECOVERY_DROP = 13'sd10;

    localparam logic [1:0] CABLE_WIRED    = 2'd0;
    localparam logic [1:0] CABLE_WIRELESS = 2'd1;
    localparam logic [1:0] CABLE_D2D      = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_COLD_COOL3    = 3'd0;
    localparam logic [2:0] REG_COOL3_COOL2   = 3'd1;
    localparam logic [2:0] REG_COOL2_COOL1   = 3'd2;
    localparam logic [2:0] REG_COOL1_NORMAL  = 3'd3;
    localparam logic [2:0] REG_NORMAL_WARM   = 3'd4;
    localparam logic [2:0] REG_WARM_OVERHEAT = 3'd5;
    localparam logic [2:0] REG_WARM_RECOVERY = 3'd6;
    localparam logic [2:0] REG_DEBOUNCE      = 3'd7;

    localparam logic [1:0] ACTION_NONE    = 2'd0;
    localparam logic [1:0] ACTION_APPLY   = 2'd1;
    localparam logic [1:0] ACTION_RELEASE = 2'd2;

    localparam logic [1:0] HEALTH_GOOD     = 2'd0;
    localparam logic [1:0] HEALTH_OVERHEAT = 2'd1;
    localparam logic [1:0] HEALTH_COLD     = 2'd2;

    localparam logic [1:0] MODE_RELEASED     = 2'd0;
    localparam logic [1:0] MODE_CHARGING     = 2'd1;
    localparam logic [1:0] MODE_CHARGING_OFF = 2'd2;
    localparam logic [1:0] MODE_BUCK_OFF     = 2'd3;

    localparam logic [2:0] CURRENT_UNCHANGED = 3'd0;
    localparam logic [2:0] CURRENT_RELEASED  = 3'd1;
    localparam logic [2:0] CURRENT_WARM      = 3'd2;
    localparam logic [2:0] CURRENT_COOL1     = 3'd3;
    localparam logic [2:0] CURRENT_COOL2     = 3'd4;
    localparam logic [2:0] CURRENT_COOL3     = 3'd5;

    localparam logic [1:0] FLOAT_UNCHANGED = 2'd0;
    localparam logic [1:0] FLOAT_RELEASED  = 2'd1;
    localparam logic [1:0] FLOAT_HIGH_TEMP = 2'd2;
    localparam logic [1:0] FLOAT_LOW_TEMP  = 2'd3;

    localparam logic [1:0] TOPOFF_UNCHANGED = 2'd0;
    localparam logic [1:0] TOPOFF_RELEASED  = 2'd1;
    localparam logic [1:0] TOPOFF_HIGH_TEMP = 2'd2;

    localparam logic [1:0] HOLD_OFF          = 2'd0;
    localparam logic [1:0] HOLD_ON           = 2'd1;
    localparam logic [1:0] HOLD_END_TRANSFER = 2'd2;

    typedef struct packed {
        temp_t cold_cool3;
        temp_t cool3_cool2;
        temp_t cool2_cool1;
        temp_t cool1_normal;
        temp_t normal_warm;
        temp_t warm_overheat;
        temp_t warm_recovery;
    } thresholds_t;

    typedef struct packed {
        logic [1:0] health;
        logic [1:0] charge_mode;
        logic [2:0] current_select;
        logic [1:0] float_select;
        logic [1:0] topoff_select;
        logic [1:0] power_hold_mode;
        logic       not_charging;
    } settings_t;

endpackage

FILE: rtl/core/battery_thermal_zone_classifier.sv
// ----------------------------------------------------------------------------
// Battery thermal zone classifier
// Pipeline: an accepted sample is held in the input register, and its result
// in the result register. Throughput: one sample per cycle; the two registers
// form a two-stage pipeline that stalls only on output back-pressure.
// Reset: asynchronous, active low; thresholds return to their defaults, the
// held zone to normal, the debounce count and the d2d latch to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_thermal_zone_classifier (
    input  logic                clk,
    input  logic                rst_n,

    // Configuration write port, no read-back.
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [11:0]         cfg_data,

    // Sample channel.
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [11:0]  temperature,
    input  logic                discharging_or_skip,
    input  logic [1:0]          cable_kind,
    input  logic                voltage_over_float,
    input  logic                voltage_over_recharge,

    // Result channel.
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          zone,
    output logic                zone_changed,
    output logic [1:0]          settings_action,
    output logic [1:0]          health,
    output logic [1:0]          charge_mode,
    output logic [2:0]          current_select,
    output logic [1:0]          float_select,
    output logic [1:0]          topoff_select,
    output logic [1:0]          power_hold_mode,
    output logic                not_charging
);

    typedef struct packed {
        btzc_pkg::zone_t     zone;
        logic                zone_changed;
        logic [1:0]          action;
        btzc_pkg::settings_t settings;
    } result_t;

    // Configuration registers. Thresholds are signed tenths of a degree.
    btzc_pkg::thresholds_t thresholds_reg;
    logic [7:0]            debounce_reg;

    // Input stage. A transfer on the sample channel loads this register; the
    // classification runs on its contents in the following cycle.
    logic                  s1_valid_reg;
    btzc_pkg::temp_t       temperature_reg;
    logic                  release_reg;
    logic [1:0]            cable_kind_reg;
    logic                  over_float_reg;
    logic                  over_recharge_reg;

    // Thermal state, updated when the input stage hands its sample on.
    btzc_pkg::zone_t       zone_reg;
    btzc_pkg::zone_t       zone_next;
    logic [7:0]            mismatch_reg;
    logic [7:0]            mismatch_next;
    logic                  d2d_reg;
    logic                  d2d_next;

    // Result stage.
    logic                  out_valid_reg;
    result_t               result_reg;
    result_t               result_next;

    logic                  s1_advance;
    btzc_pkg::zone_t       sample_zone;
    btzc_pkg::settings_t   zone_settings;
    logic [7:0]            mismatch_inc;
    logic                  commit;

    // The input stage drains whenever the result register is empty or its
    // contents are taken in the same cycle, so a new sample can follow every
    // cycle as long as each finished result is taken downstream.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresholds_reg.cold_cool3    <= 12'sd0;
            thresholds_reg.cool3_cool2   <= 12'sd50;
            thresholds_reg.cool2_cool1   <= 12'sd100;
            thresholds_reg.cool1_normal  <= 12'sd150;
            thresholds_reg.normal_warm   <= 12'sd410;
            thresholds_reg.warm_overheat <= 12'sd550;
            thresholds_reg.warm_recovery <= 12'sd390;
            debounce_reg                 <= 8'd3;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                btzc_pkg::REG_COLD_COOL3:    thresholds_reg.cold_cool3    <= cfg_data;
                btzc_pkg::REG_COOL3_COOL2:   thresholds_reg.cool3_cool2   <= cfg_data;
                btzc_pkg::REG_COOL2_COOL1:   thresholds_reg.cool2_cool1   <= cfg_data;
                btzc_pkg::REG_COOL1_NORMAL:  thresholds_reg.cool1_normal  <= cfg_data;
                btzc_pkg::REG_NORMAL_WARM:   thresholds_reg.normal_warm   <= cfg_data;
                btzc_pkg::REG_WARM_OVERHEAT: thresholds_reg.warm_overheat <= cfg_data;
                btzc_pkg::REG_WARM_RECOVERY: thresholds_reg.warm_recovery <= cfg_data;
                btzc_pkg::REG_DEBOUNCE:      debounce_reg                 <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register: the valid bit is control, the payload needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            temperature_reg   <= temperature;
            release_reg       <= discharging_or_skip;
            cable_kind_reg    <= cable_kind;
            over_float_reg    <= voltage_over_float;
            over_recharge_reg <= voltage_over_recharge;
        end
    end

    btzc_classify u_classify (
        .temperature (temperature_reg),
        .thresholds  (thresholds_reg),
        .held_zone   (zone_reg),
        .d2d_latched (d2d_reg),
        .zone        (sample_zone)
    );

    btzc_settings u_settings (
        .zone                  (sample_zone),
        .cable_kind            (cable_kind_reg),
        .voltage_over_float    (over_float_reg),
        .voltage_over_recharge (over_recharge_reg),
        .settings              (zone_settings)
    );

    // Debounce. The count saturates and is deliberately left alone when a
    // sample agrees with the held zone again; only a commit clears it. A
    // debounce setting of zero or one therefore commits on the first
    // differing sample.
    assign mismatch_inc = (mismatch_reg == 8'hFF) ? mismatch_reg : mismatch_reg + 8'd1;
    assign commit       = (sample_zone != zone_reg) && (mismatch_inc >= debounce_reg);

    always_comb
    begin
        zone_next                   = zone_reg;
        mismatch_next               = mismatch_reg;
        d2d_next                    = d2d_reg;
        result_next                 = '0;

        if (release_reg)
        begin
            // Discharging or skip: fall back to normal and release all
            // settings. The debounce count is kept as it is.
            zone_next                            = btzc_pkg::ZONE_NORMAL;
            d2d_next                             = (cable_kind_reg == btzc_pkg::CABLE_D2D);
            result_next.action                   = btzc_pkg::ACTION_RELEASE;
            result_next.settings.current_select  = btzc_pkg::CURRENT_RELEASED;
            result_next.settings.float_select    = btzc_pkg::FLOAT_RELEASED;
            result_next.settings.topoff_select   = btzc_pkg::TOPOFF_RELEASED;
        end
        else if (sample_zone != zone_reg)
        begin
            mismatch_next = mismatch_inc;
            if (commit)
            begin
                mismatch_next            = 8'd0;
                zone_next                = sample_zone;
                d2d_next                 = (cable_kind_reg == btzc_pkg::CABLE_D2D);
                result_next.zone_changed = 1'b1;
                result_next.action       = btzc_pkg::ACTION_APPLY;
                result_next.settings     = zone_settings;
            end
        end

        result_next.zone = zone_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg      <= btzc_pkg::ZONE_NORMAL;
            mismatch_reg  <= 8'd0;
            d2d_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                zone_reg      <= zone_next;
                mismatch_reg  <= mismatch_next;
                d2d_reg       <= d2d_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign zone            = result_reg.zone;
    assign zone_changed    = result_reg.zone_changed;
    assign settings_action = result_reg.action;
    assign health          = result_reg.settings.health;
    assign charge_mode     = result_reg.settings.charge_mode;
    assign current_select  = result_reg.settings.current_select;
    assign float_select    = result_reg.settings.float_select;
    assign topoff_select   = result_reg.settings.topoff_select;
    assign power_hold_mode = result_reg.settings.power_hold_mode;
    assign not_charging    = result_reg.settings.not_charging;

endmodule

FILE: rtl/core/btzc_classify.sv
// ----------------------------------------------------------------------------
// Battery thermal zone classifier: zone classification
// Adjusts the six boundaries for the held zone and sorts one sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btzc_classify (
    input  btzc_pkg::temp_t       temperature,
    input  btzc_pkg::thresholds_t thresholds,
    input  btzc_pkg::zone_t       held_zone,
    input  logic                  d2d_latched,
    output btzc_pkg::zone_t       zone
);

    btzc_pkg::bound_t t_ext;
    btzc_pkg::bound_t cc3;
    btzc_pkg::bound_t c3c2;
    btzc_pkg::bound_t c2c1;
    btzc_pkg::bound_t c1n;
    btzc_pkg::bound_t nw;
    btzc_pkg::bound_t wo;
    btzc_pkg::bound_t rec;

    always_comb
    begin
        t_ext = btzc_pkg::bound_t'(temperature);
        cc3   = btzc_pkg::bound_t'(thresholds.cold_cool3);
        c3c2  = btzc_pkg::bound_t'(thresholds.cool3_cool2);
        c2c1  = btzc_pkg::bound_t'(thresholds.cool2_cool1);
        c1n   = btzc_pkg::bound_t'(thresholds.cool1_normal);
        nw    = btzc_pkg::bound_t'(thresholds.normal_warm);
        wo    = btzc_pkg::bound_t'(thresholds.warm_overheat);
        rec   = btzc_pkg::bound_t'(thresholds.warm_recovery);

        // Hysteresis: cool zones raise the boundaries above them, hot zones
        // drop the warm boundaries to the recovery level (below it in warm with d2d).
        case (held_zone)
            btzc_pkg::ZONE_OVERHEAT:
            begin
                wo = rec;
                nw = rec;
            end
            btzc_pkg::ZONE_WARM:
            begin
                nw = d2d_latched ? rec - btzc_pkg::D2D_RECOVERY_DROP : rec;
            end
            btzc_pkg::ZONE_COLD:
            begin
                cc3  = cc3 + btzc_pkg::COOL_HYST;
                c3c2 = c3c2 + btzc_pkg::COOL_HYST;
                c2c1 = c2c1 + btzc_pkg::COOL_HYST;
                c1n  = c1n + btzc_pkg::COOL_HYST;
            end
            btzc_pkg::ZONE_COOL3:
            begin
                c3c2 = c3c2 + btzc_pkg::COOL_HYST;
                c2c1 = c2c1 + btzc_pkg::COOL_HYST;
                c1n  = c1n + btzc_pkg::COOL_HYST;
            end
            btzc_pkg::ZONE_COOL2:
            begin
                c2c1 = c2c1 + btzc_pkg::COOL_HYST;
                c1n  = c1n + btzc_pkg::COOL_HYST;
            end
            btzc_pkg::ZONE_COOL1:
            begin
                c1n = c1n + btzc_pkg::COOL_HYST;
            end
            default:
            begin
            end
        endcase

        if (t_ext >= nw)
        begin
            zone = (t_ext >= wo) ? btzc_pkg::ZONE_OVERHEAT : btzc_pkg::ZONE_WARM;
        end
        else if (t_ext <= c1n)
        begin
            if (t_ext <= cc3)
            begin
                zone = btzc_pkg::ZONE_COLD;
            end
            else if (t_ext <= c3c2)
            begin
                zone = btzc_pkg::ZONE_COOL3;
            end
            else if (t_ext <= c2c1)
            begin
                zone = btzc_pkg::ZONE_COOL2;
            end
            else
            begin
                zone = btzc_pkg::ZONE_COOL1;
            end
        end
        else
        begin
            zone = btzc_pkg::ZONE_NORMAL;
        end
    end

endmodule

FILE: rtl/core/btzc_settings.sv
// ----------------------------------------------------------------------------
// Battery thermal zone classifier: zone settings decoder
// Maps a newly committed zone and the charger conditions to setting codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btzc_settings (
    input  btzc_pkg::zone_t     zone,
    input  logic [1:0]          cable_kind,
    input  logic                voltage_over_float,
    input  logic                voltage_over_recharge,
    output btzc_pkg::settings_t settings
);

    logic wireless;

    assign wireless = (cable_kind == btzc_pkg::CABLE_WIRELESS)
                   || (cable_kind == btzc_pkg::CABLE_D2D);

    always_comb
    begin
        settings = '0;
        unique case (zone)
            btzc_pkg::ZONE_OVERHEAT:
            begin
                settings.power_hold_mode = btzc_pkg::HOLD_END_TRANSFER;
                settings.charge_mode     = voltage_over_float ? btzc_pkg::MODE_BUCK_OFF
                                                              : btzc_pkg::MODE_CHARGING_OFF;
                settings.health          = btzc_pkg::HEALTH_OVERHEAT;
                settings.not_charging    = 1'b1;
            end
            btzc_pkg::ZONE_WARM:
            begin
                settings.power_hold_mode = btzc_pkg::HOLD_ON;
                if (wireless)
                begin
                    settings.charge_mode = btzc_pkg::MODE_CHARGING_OFF;
                end
                else if (voltage_over_float)
                begin
                    settings.charge_mode = btzc_pkg::MODE_BUCK_OFF;
                end
                else if (voltage_over_recharge)
                begin
                    settings.charge_mode = btzc_pkg::MODE_CHARGING_OFF;
                end
                else
                begin
                    settings.charge_mode = btzc_pkg::MODE_CHARGING;
                end
                settings.current_select = btzc_pkg::CURRENT_WARM;
                settings.float_select   = btzc_pkg::FLOAT_HIGH_TEMP;
                settings.topoff_select  = btzc_pkg::TOPOFF_HIGH_TEMP;
            end
            btzc_pkg::ZONE_COOL1,
            btzc_pkg::ZONE_COOL2,
            btzc_pkg::ZONE_COOL3:
            begin
                if (zone == btzc_pkg::ZONE_COOL1)
                begin
                    settings.current_select = btzc_pkg::CURRENT_COOL1;
                end
                else if (zone == btzc_pkg::ZONE_COOL2)
                begin
                    settings.current_select = btzc_pkg::CURRENT_COOL2;
                end
                else
                begin
                    settings.current_select = btzc_pkg::CURRENT_COOL3;
                end
                settings.float_select  = btzc_pkg::FLOAT_LOW_TEMP;
                settings.topoff_select = btzc_pkg::TOPOFF_RELEASED;
                settings.charge_mode   = btzc_pkg::MODE_CHARGING;
            end
            btzc_pkg::ZONE_COLD:
            begin
                settings.power_hold_mode = btzc_pkg::HOLD_END_TRANSFER;
                settings.charge_mode     = btzc_pkg::MODE_CHARGING_OFF;
                settings.health          = btzc_pkg::HEALTH_COLD;
                settings.not_charging    = 1'b1;
            end
            default:
            begin
                settings.current_select = btzc_pkg::CURRENT_RELEASED;
                settings.float_select   = btzc_pkg::FLOAT_RELEASED;
                settings.topoff_select  = btzc_pkg::TOPOFF_RELEASED;
            end
        endcase
    end

endmodule

FILE: rtl/core/btzc_checker.sv
// ----------------------------------------------------------------------------
// Battery thermal zone classifier checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "battery_thermal_zone_classifier_macros.svh"

module btzc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [2:0]         zone,
    input logic               zone_changed,
    input logic [1:0]         settings_action,
    input logic [1:0]         health,
    input logic [1:0]         charge_mode,
    input logic [2:0]         current_select,
    input logic [1:0]         power_hold_mode,
    input logic               not_charging
);

    // A result held under back-pressure must not change.
    `BTZC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(zone) && $stable(settings_action) && $stable(charge_mode))

    // A committed change always comes with an apply action, and only then.
    `BTZC_ASSERT_NOW(a_change_applies, clk, rst_n, out_valid,
        zone_changed == (settings_action == btzc_pkg::ACTION_APPLY))

    // A release always leaves the block in the normal zone.
    `BTZC_ASSERT_NOW(a_release_normal, clk, rst_n,
        out_valid && settings_action == btzc_pkg::ACTION_RELEASE,
        zone == btzc_pkg::ZONE_NORMAL && current_select == btzc_pkg::CURRENT_RELEASED)

    // Without any action every checked setting code is quiet.
    `BTZC_ASSERT_NOW(a_idle_quiet, clk, rst_n,
        out_valid && settings_action == btzc_pkg::ACTION_NONE,
        health == btzc_pkg::HEALTH_GOOD && charge_mode == btzc_pkg::MODE_RELEASED
        && current_select == btzc_pkg::CURRENT_UNCHANGED && !not_charging
        && power_hold_mode == btzc_pkg::HOLD_OFF)

    // Stopping charge is reported exactly for the cold and overheat zones.
    `BTZC_ASSERT_NOW(a_not_charging_zone, clk, rst_n, out_valid && zone_changed,
        not_charging == (zone == btzc_pkg::ZONE_COLD || zone == btzc_pkg::ZONE_OVERHEAT))

endmodule

bind battery_thermal_zone_classifier btzc_checker u_btzc_checker (.*);
